@@ rtl/jetp_pkg.sv @@
// Shared types, register indexes and the saturation helper function of the Julia escape-time pixel engine.
`default_nettype none

package jetp_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_C_REAL      = 3'd0;
  localparam logic [2:0] CFG_C_IMAG      = 3'd1;
  localparam logic [2:0] CFG_ITER_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_REAL_ORIGIN = 3'd3;
  localparam logic [2:0] CFG_REAL_STEP   = 3'd4;
  localparam logic [2:0] CFG_IMAG_ORIGIN = 3'd5;
  localparam logic [2:0] CFG_IMAG_STEP   = 3'd6;
  localparam logic [2:0] CFG_MARKER_LIM  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] RST_C_REAL      = -32'sd201326592;
  localparam logic signed [31:0] RST_C_IMAG      = 32'sd0;
  localparam logic [9:0]         RST_ITER_LIMIT  = 10'd180;
  localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd429496730;
  localparam logic signed [31:0] RST_REAL_STEP   = 32'sd715828;
  localparam logic signed [31:0] RST_IMAG_ORIGIN = 32'sd322122547;
  localparam logic signed [31:0] RST_IMAG_STEP   = -32'sd715828;
  localparam logic [30:0]        RST_MARKER_LIM  = 31'd44739;

  // Escape threshold: |z|^2 = 4.0 in unsigned Q8.56.
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic [10:0] column;
    logic [9:0]  row;
  } in_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [9:0]  out_row;
    logic [9:0]  escape_count;
    logic        inside_res;
    logic        near_constant;
  } out_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic [9:0]         iteration_limit;
    logic signed [31:0] real_origin;
    logic signed [31:0] real_step;
    logic signed [31:0] imag_origin;
    logic signed [31:0] imag_step;
    logic [30:0]        marker_limit;
  } cfg_t;

  // One classified pixel handed from the front to the back end.
  typedef struct packed {
    logic [10:0]        column;
    logic [9:0]         row;
    logic signed [31:0] z0r;
    logic signed [31:0] z0i;
    logic               near;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SAT,
    F_SQR,
    F_CMP
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_UPD
  } back_state_e;

  // Clamp a signed value to the signed Q4.28 range.
  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/jetp_front.sv @@
// Front end: maps a pixel to its start point and works out the near-constant marker.
`default_nettype none

module jetp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  jetp_pkg::in_t      in_i,
  output logic               busy_o,
  input  jetp_pkg::cfg_t     cfg_i,
  input  wire logic          full_i,
  output logic               push_o,
  output jetp_pkg::job_t     job_o
);
  import jetp_pkg::*;

  front_state_e       state_q, state_d;
  logic [10:0]        col_q;
  logic [9:0]         row_q;
  logic signed [43:0] pr_q, pr_d;
  logic signed [42:0] pi_q, pi_d;
  logic signed [31:0] z0r_q, z0r_d;
  logic signed [31:0] z0i_q, z0i_d;
  logic [63:0]        sqr_q, sqr_d;
  logic [63:0]        sqi_q, sqi_d;
  logic               ok_q, ok_d;

  logic signed [11:0] col_s;
  logic signed [10:0] row_s;
  logic signed [44:0] sum_r;
  logic signed [43:0] sum_i;
  logic signed [32:0] dr;
  logic signed [32:0] di;
  logic signed [31:0] dr_l;
  logic signed [31:0] di_l;
  logic               dr_ok;
  logic               di_ok;
  logic [63:0]        d2;
  logic               near;

  // Offsets along each axis: pixel index times step.
  assign col_s = $signed({1'b0, col_q});
  assign row_s = $signed({1'b0, row_q});
  assign pr_d  = col_s * cfg_i.real_step;
  assign pi_d  = row_s * cfg_i.imag_step;

  // Start point, saturated to Q4.28.
  assign sum_r = 45'(cfg_i.real_origin) + 45'(pr_q);
  assign sum_i = 44'(cfg_i.imag_origin) + 44'(pi_q);
  assign z0r_d = sat32(64'(sum_r));
  assign z0i_d = sat32(64'(sum_i));

  // Distance to c; a difference of magnitude 2^31 or more is never near.
  assign dr    = 33'(z0r_q) - 33'(cfg_i.c_real);
  assign di    = 33'(z0i_q) - 33'(cfg_i.c_imag);
  assign dr_ok = (dr[32:31] == 2'b00) || ((dr[32:31] == 2'b11) && (dr[30:0] != '0));
  assign di_ok = (di[32:31] == 2'b00) || ((di[32:31] == 2'b11) && (di[30:0] != '0));
  assign dr_l  = dr[31:0];
  assign di_l  = di[31:0];
  assign sqr_d = 64'(dr_l * dr_l);
  assign sqi_d = 64'(di_l * di_l);
  assign ok_d  = dr_ok && di_ok;

  // Squared distance back in Q4.28 against the marker limit.
  assign d2   = (sqr_q + sqi_q) >> 28;
  assign near = ok_q && (d2 < 64'(cfg_i.marker_limit));

  assign job_o.column = col_q;
  assign job_o.row    = row_q;
  assign job_o.z0r    = z0r_q;
  assign job_o.z0i    = z0i_q;
  assign job_o.near   = near;

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      col_q <= in_i.column;
      row_q <= in_i.row;
    end
    if (state_q == F_MUL) begin
      pr_q <= pr_d;
      pi_q <= pi_d;
    end
    if (state_q == F_SAT) begin
      z0r_q <= z0r_d;
      z0i_q <= z0i_d;
    end
    if (state_q == F_SQR) begin
      sqr_q <= sqr_d;
      sqi_q <= sqi_d;
      ok_q  <= ok_d;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d = state_q;
    busy_o  = 1'b1;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = F_MUL;
        end
      end
      F_MUL: state_d = F_SAT;
      F_SAT: state_d = F_SQR;
      F_SQR: state_d = F_CMP;
      F_CMP: begin
        // Hold the finished beat until the queue has room.
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/jetp_queue.sv @@
// Short queue of classified pixels between the front and the back end.
`default_nettype none

module jetp_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  jetp_pkg::job_t job_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           empty_o,
  output jetp_pkg::job_t job_o
);
  import jetp_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jetp_back.sv @@
// Back end: iterates z = z*z + c on one pixel at a time and reports the escape count.
`default_nettype none

module jetp_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  jetp_pkg::cfg_t cfg_i,
  input  wire logic      empty_i,
  input  jetp_pkg::job_t job_i,
  output logic           pop_o,
  output logic           done_o,
  output jetp_pkg::out_t res_o
);
  import jetp_pkg::*;

  back_state_e        state_q, state_d;
  logic [10:0]        col_q, col_d;
  logic [9:0]         row_q, row_d;
  logic               near_q, near_d;
  logic signed [31:0] zr_q, zr_d;
  logic signed [31:0] zi_q, zi_d;
  logic signed [63:0] prr_q, pii_q, pri_q;
  logic [9:0]         k_q, k_d;
  logic               upd_q, upd_d;
  logic               done_q, done_d;
  out_t               res_q, res_d;

  logic [63:0]        mag;
  logic               esc;
  logic signed [63:0] diff;
  logic signed [35:0] nr;
  logic signed [36:0] ni;
  logic signed [37:0] sum_r;
  logic signed [37:0] sum_i;

  // Escape test on the products of the latest z.
  assign mag = 64'(prr_q) + 64'(pii_q);
  assign esc = upd_q && (mag > ESCAPE_LIMIT);

  // Next z: floor-shifted square plus c, saturated.
  assign diff  = prr_q - pii_q;
  assign nr    = diff[63:28];
  assign ni    = pri_q[63:27];
  assign sum_r = 38'(nr) + 38'(cfg_i.c_real);
  assign sum_i = 38'(ni) + 38'(cfg_i.c_imag);

  assign done_o = done_q;
  assign res_o  = res_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers; products are taken once per iteration.
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    near_q <= near_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    k_q    <= k_d;
    upd_q  <= upd_d;
    res_q  <= res_d;
    if (state_q == B_MUL) begin
      prr_q <= zr_q * zr_q;
      pii_q <= zi_q * zi_q;
      pri_q <= zr_q * zi_q;
    end
  end

  // Iteration sequencer.
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    near_d  = near_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    k_d     = k_q;
    upd_d   = upd_q;
    res_d   = res_q;
    done_d  = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          col_d  = job_i.column;
          row_d  = job_i.row;
          near_d = job_i.near;
          zr_d   = job_i.z0r;
          zi_d   = job_i.z0i;
          k_d    = '0;
          upd_d  = 1'b0;
          if (cfg_i.iteration_limit == '0) begin
            // No iteration at all: the point counts as inside.
            done_d              = 1'b1;
            res_d.out_column    = job_i.column;
            res_d.out_row       = job_i.row;
            res_d.escape_count  = '0;
            res_d.inside_res    = 1'b1;
            res_d.near_constant = job_i.near;
          end else begin
            state_d = B_MUL;
          end
        end
      end
      B_MUL: state_d = B_UPD;
      B_UPD: begin
        if (esc) begin
          // Escaped after the update counted one below k.
          done_d              = 1'b1;
          res_d.out_column    = col_q;
          res_d.out_row       = row_q;
          res_d.escape_count  = k_q - 1'b1;
          res_d.inside_res    = 1'b0;
          res_d.near_constant = near_q;
          state_d             = B_IDLE;
        end else if (k_q == cfg_i.iteration_limit) begin
          done_d              = 1'b1;
          res_d.out_column    = col_q;
          res_d.out_row       = row_q;
          res_d.escape_count  = k_q;
          res_d.inside_res    = 1'b1;
          res_d.near_constant = near_q;
          state_d             = B_IDLE;
        end else begin
          zr_d    = sat32(64'(sum_r));
          zi_d    = sat32(64'(sum_i));
          k_d     = k_q + 1'b1;
          upd_d   = 1'b1;
          state_d = B_MUL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/julia_escape_time_pixel.sv @@
// Top level of the Julia escape-time pixel engine: configuration registers and the two ends.
// A pixel passes the front end's states F_MUL, F_SAT, F_SQR and F_CMP, waits in the queue and
// is iterated by the back end in B_MUL and B_UPD, at most iteration_limit times, or reported as
// inside without iterating when the limit is zero. Each end works on one pixel at a time; the
// front end accepts only in F_IDLE, busy_o is high otherwise, and F_CMP waits on a full queue.
// Reset clears the sequencers and queue and loads the configuration registers with their
// defaults; done_o is a single-cycle strobe and the receiver cannot stall it.
`default_nettype none

module julia_escape_time_pixel (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  jetp_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           done_o,
  output jetp_pkg::out_t res_o,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import jetp_pkg::*;

  cfg_t cfg_q;
  logic full;
  logic empty;
  logic push;
  logic pop;
  job_t job_in;
  job_t job_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real          <= RST_C_REAL;
      cfg_q.c_imag          <= RST_C_IMAG;
      cfg_q.iteration_limit <= RST_ITER_LIMIT;
      cfg_q.real_origin     <= RST_REAL_ORIGIN;
      cfg_q.real_step       <= RST_REAL_STEP;
      cfg_q.imag_origin     <= RST_IMAG_ORIGIN;
      cfg_q.imag_step       <= RST_IMAG_STEP;
      cfg_q.marker_limit    <= RST_MARKER_LIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_C_REAL:      cfg_q.c_real          <= cfg_data_i;
        CFG_C_IMAG:      cfg_q.c_imag          <= cfg_data_i;
        CFG_ITER_LIMIT:  cfg_q.iteration_limit <= cfg_data_i[9:0];
        CFG_REAL_ORIGIN: cfg_q.real_origin     <= cfg_data_i;
        CFG_REAL_STEP:   cfg_q.real_step       <= cfg_data_i;
        CFG_IMAG_ORIGIN: cfg_q.imag_origin     <= cfg_data_i;
        CFG_IMAG_STEP:   cfg_q.imag_step       <= cfg_data_i;
        CFG_MARKER_LIM:  cfg_q.marker_limit    <= cfg_data_i[30:0];
        default: begin
        end
      endcase
    end
  end

  // Start point and marker.
  jetp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job_in)
  );

  // Decoupling queue.
  jetp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  // Iteration engine.
  jetp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
